// ===== hw/rtl/alah_pkg.sv =====
// ---------------------------------------------------------------------------
// alah_pkg: ambient-light headlight controller package
// Action, mode, lamp and command codes, fixed levels and beam frame words.
// ---------------------------------------------------------------------------
`default_nettype none

package alah_pkg;

   localparam int LUX_W = 16;
   localparam int PAY_W = 48;

   typedef logic [1:0]       action_type;
   typedef logic [1:0]       mode_type;
   typedef logic [1:0]       lamp_type;
   typedef logic [2:0]       cmd_type;
   typedef logic [PAY_W-1:0] pay_type;

   localparam action_type ACT_SAMPLE  = 2'd0;
   localparam action_type ACT_MODE    = 2'd1;
   localparam action_type ACT_RESTORE = 2'd2;
   localparam action_type ACT_FADE    = 2'd3;

   localparam mode_type MODE_OFF  = 2'd0;
   localparam mode_type MODE_ON   = 2'd1;
   localparam mode_type MODE_DIM  = 2'd2;
   localparam mode_type MODE_AUTO = 2'd3;

   localparam lamp_type LAMP_OFF   = 2'd0;
   localparam lamp_type LAMP_ON    = 2'd1;
   localparam lamp_type LAMP_DIM   = 2'd2;
   localparam lamp_type LAMP_THREE = 2'd3;

   localparam cmd_type CMD_FRONT_LEVEL = 3'd0;
   localparam cmd_type CMD_REAR_LEVEL  = 3'd1;
   localparam cmd_type CMD_FRONT_FRAME = 3'd2;
   localparam cmd_type CMD_REAR_FRAME  = 3'd3;
   localparam cmd_type CMD_BRIGHTNESS  = 3'd4;
   localparam cmd_type CMD_DARK        = 3'd5;
   localparam cmd_type CMD_LIGHTER     = 3'd6;

   localparam logic [LUX_W-1:0] DARK_RESET   = 16'h0032;
   localparam logic [LUX_W-1:0] BRIGHT_RESET = 16'h008c;

   localparam logic [7:0] LEVEL_ON   = 8'd200;
   localparam logic [7:0] LEVEL_DIM  = 8'd50;
   localparam logic [7:0] FADE_RESET = 8'd10;
   localparam logic [7:0] FADE_STEP  = 8'd10;
   localparam logic [7:0] FADE_TOP   = 8'd100;

   localparam logic [31:0] LO_HI_FRONT  = 32'h8b060001;
   localparam logic [31:0] LO_HI_REAR   = 32'h5a020001;
   localparam logic [31:0] LO_LOW       = 32'h3c020001;
   localparam logic [31:0] LO_RAISE     = 32'h3c060001;
   localparam logic [15:0] MID_STEADY   = 16'h0101;
   localparam logic [15:0] MID_DROP_F   = 16'h2301;
   localparam logic [15:0] MID_REAR_T   = 16'h1e01;
   localparam logic [15:0] MID_RAISE_F  = 16'h4f01;

   // beam frame: mid word above the low 32 bits
   function automatic pay_type frame_pay(input logic rear, input logic high,
                                         input logic trans);
      logic [15:0] mid;
      logic [31:0] lo;
      mid = MID_STEADY;
      lo  = LO_LOW;
      if (high) begin
         if (trans) begin
            mid = rear ? MID_REAR_T : MID_RAISE_F;
            lo  = rear ? LO_LOW : LO_RAISE;
         end else begin
            lo  = rear ? LO_HI_REAR : LO_HI_FRONT;
         end
      end else if (trans) begin
         mid = rear ? MID_REAR_T : MID_DROP_F;
         lo  = rear ? LO_HI_REAR : LO_HI_FRONT;
      end
      return {mid, lo};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ambient_light_auto_headlight.sv =====
// ---------------------------------------------------------------------------
// ambient_light_auto_headlight: ambient-light headlight controller
// Lux ring with floor average, dark/lighter hysteresis, lamp and beam
// sequencing, mode control and brightness fade.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                             tuser        tlast
//  req_     in   [15:0] lux [16] force [18:17] mode [1:0] action  -
//  rsp_     out  [47:0] payload                    [2:0] command last
//  csr_     in   csr_index 0 dark_level, 1 bright_level, csr_wdata 16 bits
//
//  Sample items (lux sample, auto mode, restore in auto) pass through
//  write, ring sweep, divide, decide and emit; the sweep reads the ring
//  through the single RAM read port and the divider is bit-serial.
//  Other items go straight to decide and emit. Up to 7 results per item.
//  req_tready is low while an item is at work; a stalled rsp_ holds.
//  Synchronous active-high reset; ring contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ambient_light_auto_headlight
   import alah_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // lux[15:0], force_req[16], mode_value[18:17]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // payload[47:0]
   output logic      [2:0]  rsp_tuser,   // command[2:0]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = LUX_W + ADDR_W;

   localparam logic [2:0] SL_EV  = 3'd0;
   localparam logic [2:0] SL_LF  = 3'd1;
   localparam logic [2:0] SL_LR  = 3'd2;
   localparam logic [2:0] SL_TF  = 3'd3;
   localparam logic [2:0] SL_TR  = 3'd4;
   localparam logic [2:0] SL_SF  = 3'd5;
   localparam logic [2:0] SL_SR  = 3'd6;
   localparam logic [2:0] SL_BRT = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_SUM, ST_DIV, ST_DECIDE, ST_EMIT
   } state_type;

   state_type         state_ff,   state_in;
   action_type        act_ff,     act_in;
   logic              force_ff,   force_in;
   mode_type          mode_ff,    mode_in;
   logic [LUX_W-1:0]  smp_val_ff, smp_val_in;
   logic [LUX_W-1:0]  dark_lvl_ff;
   logic [LUX_W-1:0]  bright_lvl_ff;
   logic [ADDR_W-1:0] wpos_ff,    wpos_in;
   logic [FILL_W-1:0] filled_ff,  filled_in;
   logic [LUX_W-1:0]  avg_ff,     avg_in;
   mode_type          lmode_ff,   lmode_in;
   logic              dark_ff,    dark_in;
   logic              en_ff,      en_in;
   lamp_type          lamp_ff,    lamp_in;
   logic              high_ff,    high_in;
   logic              beamon_ff,  beamon_in;
   logic [7:0]        fade_ff,    fade_in;
   logic [FILL_W-1:0] cnt_ff,     cnt_in;
   logic              rd_vld_ff,  rd_vld_in;
   logic [SUM_W-1:0]  acc_ff,     acc_in;
   logic [7:0]        mask_ff,    mask_in;
   cmd_type           ev_cmd_ff,  ev_cmd_in;
   logic [7:0]        lvl_ff,     lvl_in;
   logic              rhigh_ff,   rhigh_in;
   logic              rsp_vld_ff, rsp_vld_in;
   cmd_type           rsp_cmd_ff, rsp_cmd_in;
   pay_type           rsp_pay_ff, rsp_pay_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              smp_req;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_raddr;
   logic [LUX_W-1:0]  ram_rdata;
   logic              issue;
   logic              div_start;
   logic              div_done;
   logic [SUM_W-1:0]  div_quo;
   logic              load;
   logic [2:0]        sel;

   // decision terms
   logic [7:0]        p_mask;
   cmd_type           p_ev_cmd;
   logic [7:0]        p_lvl;
   logic              p_rhigh;
   logic              p_dark;
   lamp_type          p_lamp;
   logic              p_high;
   logic              p_beamon;
   logic [7:0]        p_fade;
   logic              go_on;
   logic              go_dim;
   logic              go_off;

   alah_ram #(
      .WIDTH(LUX_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wpos_ff),
      .wdata (smp_val_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   alah_div #(
      .DVD_W(SUM_W),
      .DVS_W(FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (filled_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ram_we     = (state_ff == ST_WRITE);
   assign ram_raddr  = cnt_ff[ADDR_W-1:0];
   assign issue      = (state_ff == ST_SUM) && (cnt_ff < filled_ff);
   assign div_start  = (state_ff == ST_SUM) && !issue && !rd_vld_ff;
   assign smp_req    = (req_tuser == ACT_SAMPLE)
                    || (req_tuser == ACT_MODE && req_tdata[18:17] == MODE_AUTO)
                    || (req_tuser == ACT_RESTORE && lmode_ff == MODE_AUTO);

   // outcome of one item, from the state and the latched item
   always_comb begin
      p_mask   = '0;
      p_ev_cmd = CMD_DARK;
      p_lvl    = LEVEL_ON;
      p_rhigh  = 1'b1;
      p_dark   = dark_ff;
      p_lamp   = lamp_ff;
      p_high   = high_ff;
      p_beamon = beamon_ff;
      p_fade   = fade_ff;
      go_on    = 1'b0;
      go_dim   = 1'b0;
      go_off   = 1'b0;
      if (act_ff == ACT_FADE) begin
         if (beamon_ff) begin
            if (fade_ff < FADE_TOP) begin
               p_fade = fade_ff + FADE_STEP;
            end
         end else if (fade_ff != '0) begin
            p_fade = fade_ff - FADE_STEP;
         end
         p_mask[SL_BRT] = 1'b1;
      end else if (act_ff == ACT_SAMPLE || mode_ff == MODE_AUTO) begin
         if (en_ff) begin
            if (avg_ff < dark_lvl_ff) begin
               if (force_ff || !dark_ff) begin
                  p_mask[SL_EV] = 1'b1;
                  p_ev_cmd      = CMD_DARK;
                  p_dark        = 1'b1;
               end
            end else if (avg_ff > bright_lvl_ff) begin
               if (force_ff || dark_ff) begin
                  p_mask[SL_EV] = 1'b1;
                  p_ev_cmd      = CMD_LIGHTER;
                  p_dark        = 1'b0;
               end
            end
            if (lmode_ff == MODE_AUTO && (force_ff || lamp_ff != LAMP_THREE)) begin
               go_on  = p_dark && (lamp_ff != LAMP_ON);
               go_dim = !p_dark && (lamp_ff != LAMP_DIM);
            end
         end
      end else begin
         unique case (mode_ff)
            MODE_ON:  go_on  = force_ff || (lamp_ff != LAMP_ON);
            MODE_DIM: go_dim = force_ff || (lamp_ff != LAMP_DIM);
            MODE_OFF: go_off = force_ff || (lamp_ff != LAMP_OFF);
            default:  go_off = 1'b0;
         endcase
      end
      if (go_on || go_dim) begin
         p_mask[SL_LF] = 1'b1;
         p_mask[SL_LR] = 1'b1;
         p_lvl         = go_on ? LEVEL_ON : LEVEL_DIM;
         p_lamp        = go_on ? LAMP_ON : LAMP_DIM;
      end
      if (go_off) begin
         p_lamp = LAMP_OFF;
      end
      if (go_on || go_dim || go_off) begin
         p_rhigh       = !go_off;
         p_mask[SL_TF] = (p_rhigh != high_ff);
         p_mask[SL_TR] = (p_rhigh != high_ff);
         p_mask[SL_SF] = 1'b1;
         p_mask[SL_SR] = 1'b1;
         p_beamon      = go_on;
         p_high        = p_rhigh;
      end
   end

   // lowest pending result slot
   always_comb begin
      sel = SL_BRT;
      for (int i = 7; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = 3'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      force_in    = force_ff;
      mode_in     = mode_ff;
      smp_val_in  = smp_val_ff;
      wpos_in     = wpos_ff;
      filled_in   = filled_ff;
      avg_in      = avg_ff;
      lmode_in    = lmode_ff;
      dark_in     = dark_ff;
      en_in       = en_ff;
      lamp_in     = lamp_ff;
      high_in     = high_ff;
      beamon_in   = beamon_ff;
      fade_in     = fade_ff;
      cnt_in      = cnt_ff;
      rd_vld_in   = 1'b0;
      acc_in      = acc_ff;
      mask_in     = mask_ff;
      ev_cmd_in   = ev_cmd_ff;
      lvl_in      = lvl_ff;
      rhigh_in    = rhigh_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_cmd_in  = rsp_cmd_ff;
      rsp_pay_in  = rsp_pay_ff;
      rsp_last_in = rsp_last_ff;
      load        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in     = req_tuser;
               force_in   = (req_tuser == ACT_SAMPLE)
                         || (req_tuser == ACT_MODE && req_tdata[18:17] != MODE_AUTO)
                          ? req_tdata[16] : 1'b0;
               mode_in    = (req_tuser == ACT_RESTORE) ? lmode_ff : req_tdata[18:17];
               smp_val_in = (req_tuser == ACT_SAMPLE) ? req_tdata[15:0] : avg_ff;
               if (req_tuser == ACT_MODE) begin
                  lmode_in = req_tdata[18:17];
               end
               if (req_tuser == ACT_RESTORE) begin
                  en_in = 1'b1;
               end
               state_in = smp_req ? ST_WRITE : ST_DECIDE;
            end
         end
         ST_WRITE: begin
            wpos_in   = (wpos_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
            filled_in = (filled_ff < FILL_W'(RING_DEPTH)) ? filled_ff + 1'b1 : filled_ff;
            cnt_in    = '0;
            acc_in    = '0;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            rd_vld_in = issue;
            if (rd_vld_ff) begin
               acc_in = acc_ff + SUM_W'(ram_rdata);
            end
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quo[LUX_W-1:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            mask_in   = p_mask;
            ev_cmd_in = p_ev_cmd;
            lvl_in    = p_lvl;
            rhigh_in  = p_rhigh;
            dark_in   = p_dark;
            lamp_in   = p_lamp;
            high_in   = p_high;
            beamon_in = p_beamon;
            fade_in   = p_fade;
            state_in  = (p_mask == '0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            load = !rsp_vld_ff || rsp_tready;
            if (load) begin
               mask_in        = mask_ff;
               mask_in[sel]   = 1'b0;
               rsp_vld_in     = 1'b1;
               rsp_last_in    = (mask_in == '0);
               unique case (sel)
                  SL_EV: begin
                     rsp_cmd_in = ev_cmd_ff;
                     rsp_pay_in = '0;
                  end
                  SL_LF: begin
                     rsp_cmd_in = CMD_FRONT_LEVEL;
                     rsp_pay_in = PAY_W'(lvl_ff);
                  end
                  SL_LR: begin
                     rsp_cmd_in = CMD_REAR_LEVEL;
                     rsp_pay_in = PAY_W'(lvl_ff);
                  end
                  SL_TF: begin
                     rsp_cmd_in = CMD_FRONT_FRAME;
                     rsp_pay_in = frame_pay(1'b0, rhigh_ff, 1'b1);
                  end
                  SL_TR: begin
                     rsp_cmd_in = CMD_REAR_FRAME;
                     rsp_pay_in = frame_pay(1'b1, rhigh_ff, 1'b1);
                  end
                  SL_SF: begin
                     rsp_cmd_in = CMD_FRONT_FRAME;
                     rsp_pay_in = frame_pay(1'b0, rhigh_ff, 1'b0);
                  end
                  SL_SR: begin
                     rsp_cmd_in = CMD_REAR_FRAME;
                     rsp_pay_in = frame_pay(1'b1, rhigh_ff, 1'b0);
                  end
                  SL_BRT: begin
                     rsp_cmd_in = CMD_BRIGHTNESS;
                     rsp_pay_in = PAY_W'(fade_ff);
                  end
               endcase
               if (mask_in == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dark_lvl_ff   <= DARK_RESET;
         bright_lvl_ff <= BRIGHT_RESET;
         wpos_ff       <= '0;
         filled_ff     <= '0;
         avg_ff        <= '0;
         lmode_ff      <= MODE_AUTO;
         dark_ff       <= 1'b0;
         en_ff         <= 1'b0;
         lamp_ff       <= LAMP_OFF;
         high_ff       <= 1'b0;
         beamon_ff     <= 1'b0;
         fade_ff       <= FADE_RESET;
         rd_vld_ff     <= 1'b0;
         mask_ff       <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wpos_ff    <= wpos_in;
         filled_ff  <= filled_in;
         avg_ff     <= avg_in;
         lmode_ff   <= lmode_in;
         dark_ff    <= dark_in;
         en_ff      <= en_in;
         lamp_ff    <= lamp_in;
         high_ff    <= high_in;
         beamon_ff  <= beamon_in;
         fade_ff    <= fade_in;
         rd_vld_ff  <= rd_vld_in;
         mask_ff    <= mask_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we && !csr_index) begin
            dark_lvl_ff <= csr_wdata;
         end
         if (csr_we && csr_index) begin
            bright_lvl_ff <= csr_wdata;
         end
      end
      act_ff      <= act_in;
      force_ff    <= force_in;
      mode_ff     <= mode_in;
      smp_val_ff  <= smp_val_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      ev_cmd_ff   <= ev_cmd_in;
      lvl_ff      <= lvl_in;
      rhigh_ff    <= rhigh_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_pay_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (mask_ff == '0))
      else $error("item accepted while results pending");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(RING_DEPTH))
      else $error("ring fill count overflow");

   a_sum_to_div: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV))
      else $error("divide not entered after ring sweep");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/alah_ram.sv =====
// ---------------------------------------------------------------------------
// alah_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module alah_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/alah_div.sv =====
// ---------------------------------------------------------------------------
// alah_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ---------------------------------------------------------------------------
`default_nettype none

module alah_div #(
   parameter int DVD_W = 20,
   parameter int DVS_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff,  rem_in;
   logic [DVD_W-1:0] quo_ff,  quo_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      if (start) begin
         dvs_ff <= divisor;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
